### hdl/modem_power_sequencer_defines.svh
// Assertion macros shared by the sequencer checks.
// Both expect clk and arst_n in scope.
`ifndef MODEM_POWER_SEQUENCER_DEFINES_SVH
`define MODEM_POWER_SEQUENCER_DEFINES_SVH

// Same-cycle implication
`define MPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("modem power sequencer check failed");

// Next-cycle implication
`define MPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("modem power sequencer check failed");

`endif

### hdl/mps_pkg.sv
`default_nettype none

package mps_pkg;

	// Timer width default
	localparam int TIMER_WIDTH_DEF = 16;

	// Opcodes of an input transaction
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ON   = 2'd1;
	localparam logic [1:0] OP_OFF  = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] CFG_HAS_CONTROL   = 3'd0;
	localparam logic [2:0] CFG_HAS_FEEDBACK  = 3'd1;
	localparam logic [2:0] CFG_HAS_REGULATOR = 3'd2;
	localparam logic [2:0] CFG_CAN_TURNOFF   = 3'd3;
	localparam logic [2:0] CFG_IMPULSE       = 3'd4;
	localparam logic [2:0] CFG_ON_SETTLE     = 3'd5;
	localparam logic [2:0] CFG_OFF_SETTLE    = 3'd6;
	localparam logic [2:0] CFG_RESET_HOLD    = 3'd7;

	// Fixed waits and register reset values
	localparam logic [15:0] WAIT_RAMP      = 16'd200;
	localparam logic [15:0] WAIT_USBOFF    = 16'd10;
	localparam logic [15:0] IMPULSE_RST    = 16'd600;
	localparam logic [15:0] ON_SETTLE_RST  = 16'd6000;
	localparam logic [15:0] OFF_SETTLE_RST = 16'd1000;
	localparam logic [15:0] RESET_HOLD_RST = 16'd2500;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_RAMP   = 3'd1,
		PH_KEY    = 3'd2,
		PH_SETTLE = 3'd3,
		PH_USBOFF = 3'd4,
		PH_RESET  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		OC_NONE     = 3'd0,
		OC_OK       = 3'd1,
		OC_MISMATCH = 3'd2,
		OC_REJECTED = 3'd3,
		OC_REGONLY  = 3'd4
	} outcome_t;

endpackage

`default_nettype wire

### hdl/modem_power_sequencer.sv
// Each transaction passes the input register, then the result register.
// Throughput: one transaction per cycle; the input register and the result
// register form a two-stage pipeline that stalls only while out_ready is low.
// Reset (arst_n low, asynchronous): phase idle, count zero, regulator off,
// modem reset asserted, USB enabled, key low, registers at their defaults.
`default_nettype none

module modem_power_sequencer #(
	parameter int TIMER_WIDTH = mps_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic        feedback_level,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             supply_enable,
	output logic             reset_level,
	output logic             usb_enable,
	output logic             key_level,
	output logic             powered,
	output logic             busy_res,
	output logic [2:0]       outcome
);
	import mps_pkg::*;

	localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

	// Clamp a loaded wait to the counter range
	function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [15:0] n);
		logic [32:0] n_ext;
		n_ext = {17'd0, n};
		if (n_ext > TMAX)
			return TMAX[TIMER_WIDTH-1:0];
		return n_ext[TIMER_WIDTH-1:0];
	endfunction

	// configuration registers
	logic        has_control_q, has_feedback_q, has_regulator_q, can_turnoff_q;
	logic [15:0] impulse_q, on_settle_q, off_settle_q, reset_hold_q;

	// sequencer state
	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] count_q, count_d;
	logic                   believed_q, believed_d;
	logic                   target_q, target_d;
	logic                   reg_q, reg_d;
	logic                   rst_q, rst_d;
	logic                   usb_q, usb_d;
	logic                   key_q, key_d;
	outcome_t               res_d;
	logic                   powered_d;

	// pipeline registers
	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic       fb_s1;
	logic       valid_s2;
	logic       reg_s2, rst_s2, usb_s2, key_s2, powered_s2, busy_s2;
	outcome_t   outcome_s2;

	logic adv;
	logic fire_s1;
	logic req_on;
	logic report_pre;
	logic report_fin;

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire_s1  = valid_s1 && adv;
	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_control_q   <= 1'b1;
			has_feedback_q  <= 1'b0;
			has_regulator_q <= 1'b1;
			can_turnoff_q   <= 1'b0;
			impulse_q       <= IMPULSE_RST;
			on_settle_q     <= ON_SETTLE_RST;
			off_settle_q    <= OFF_SETTLE_RST;
			reset_hold_q    <= RESET_HOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HAS_CONTROL:   has_control_q   <= cfg_data[0];
				CFG_HAS_FEEDBACK:  has_feedback_q  <= cfg_data[0];
				CFG_HAS_REGULATOR: has_regulator_q <= cfg_data[0];
				CFG_CAN_TURNOFF:   can_turnoff_q   <= cfg_data[0];
				CFG_IMPULSE:       impulse_q       <= cfg_data;
				CFG_ON_SETTLE:     on_settle_q     <= cfg_data;
				CFG_OFF_SETTLE:    off_settle_q    <= cfg_data;
				CFG_RESET_HOLD:    reset_hold_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			fb_s1     <= feedback_level;
		end
	end

	// Reported power before and after a finishing step
	assign req_on     = (opcode_s1 == OP_ON);
	assign report_pre = has_feedback_q ? fb_s1 : (!has_control_q ? 1'b1 : believed_q);
	assign report_fin = has_feedback_q ? fb_s1 : (!has_control_q ? 1'b1 : target_q);

	// Next state and result of the transaction in the input register
	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		believed_d = believed_q;
		target_d   = target_q;
		reg_d      = reg_q;
		rst_d      = rst_q;
		usb_d      = usb_q;
		key_d      = key_q;
		res_d      = OC_NONE;
		if (fire_s1) begin
			if (opcode_s1 == OP_ON || opcode_s1 == OP_OFF) begin
				// handle a power request
				if (phase_q != PH_IDLE || !has_control_q) begin
					res_d = OC_REJECTED;
				end else if (report_pre != req_on) begin
					target_d = req_on;
					if (req_on && has_regulator_q && !reg_q) begin
						reg_d   = 1'b1;
						rst_d   = 1'b0;
						phase_d = PH_RAMP;
						count_d = sat_load(WAIT_RAMP);
					end else if (!req_on && !can_turnoff_q) begin
						if (has_regulator_q)
							reg_d = 1'b0;
						res_d = OC_REGONLY;
					end else begin
						key_d   = 1'b1;
						phase_d = PH_KEY;
						count_d = sat_load(impulse_q);
					end
				end
			end else if (opcode_s1 == OP_TICK && phase_q != PH_IDLE) begin
				if (count_q <= TIMER_WIDTH'(1)) begin
					// advance the sequence
					unique case (phase_q)
						PH_RAMP: begin
							usb_d   = 1'b1;
							key_d   = 1'b1;
							phase_d = PH_KEY;
							count_d = sat_load(impulse_q);
						end
						PH_KEY: begin
							key_d   = 1'b0;
							phase_d = PH_SETTLE;
							count_d = sat_load(target_q ? on_settle_q : off_settle_q);
						end
						PH_SETTLE: begin
							if (target_q) begin
								believed_d = target_q;
								phase_d    = PH_IDLE;
								count_d    = '0;
								if (report_fin != target_q) begin
									if (has_regulator_q)
										reg_d = 1'b0;
									res_d = OC_MISMATCH;
								end else begin
									res_d = OC_OK;
								end
							end else begin
								usb_d   = 1'b0;
								phase_d = PH_USBOFF;
								count_d = sat_load(WAIT_USBOFF);
							end
						end
						PH_USBOFF: begin
							rst_d   = 1'b1;
							phase_d = PH_RESET;
							count_d = sat_load(reset_hold_q);
						end
						PH_RESET: begin
							rst_d      = 1'b0;
							reg_d      = 1'b0;
							believed_d = target_q;
							phase_d    = PH_IDLE;
							count_d    = '0;
							res_d      = (report_fin != target_q) ? OC_MISMATCH : OC_OK;
						end
						default: begin
							phase_d = PH_IDLE;
							count_d = '0;
						end
					endcase
				end else begin
					count_d = count_q - TIMER_WIDTH'(1);
				end
			end
		end
		powered_d = has_feedback_q ? fb_s1 : (!has_control_q ? 1'b1 : believed_d);
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			count_q    <= '0;
			believed_q <= 1'b0;
			target_q   <= 1'b0;
			reg_q      <= 1'b0;
			rst_q      <= 1'b1;
			usb_q      <= 1'b1;
			key_q      <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			believed_q <= believed_d;
			target_q   <= target_d;
			reg_q      <= reg_d;
			rst_q      <= rst_d;
			usb_q      <= usb_d;
			key_q      <= key_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			reg_s2     <= reg_d;
			rst_s2     <= rst_d;
			usb_s2     <= usb_d;
			key_s2     <= key_d;
			powered_s2 <= powered_d;
			busy_s2    <= (phase_d != PH_IDLE);
			outcome_s2 <= res_d;
		end
	end

	assign out_valid     = valid_s2;
	assign supply_enable = reg_s2;
	assign reset_level   = rst_s2;
	assign usb_enable    = usb_s2;
	assign key_level     = key_s2;
	assign powered       = powered_s2;
	assign busy_res      = busy_s2;
	assign outcome       = outcome_s2;

endmodule

`default_nettype wire

### hdl/mps_checker.sv
`default_nettype none
`include "modem_power_sequencer_defines.svh"

module mps_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       supply_enable,
	input wire logic       key_level,
	input wire logic       busy_res,
	input wire logic [2:0] outcome
);
	import mps_pkg::*;

	// a stalled result transaction holds
	`MPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(outcome))

	// a finished sequence leaves the sequencer idle
	`MPS_ASSERT_NOW(a_finish_idle, out_valid && (outcome == OC_OK || outcome == OC_MISMATCH), !busy_res)

	// a refused power-off leaves the regulator dropped and the sequencer idle
	`MPS_ASSERT_NOW(a_regonly_off, out_valid && outcome == OC_REGONLY, !supply_enable && !busy_res)

	// the key pin is only driven inside a sequence
	`MPS_ASSERT_NOW(a_key_idle, out_valid && !busy_res, !key_level)

endmodule

bind modem_power_sequencer mps_checker u_mps_checker (.*);

`default_nettype wire

### verif/power_sequence_checker.sv
`timescale 1ns / 1ps

module power_sequence_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic        feedback_level,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        supply_enable,
	input  logic        reset_level,
	input  logic        usb_enable,
	input  logic        key_level,
	input  logic        powered,
	input  logic        busy_res,
	input  logic [2:0]  outcome,
	output int          mismatches,
	output int          pending
);
	import mps_pkg::*;

	typedef struct packed {
		logic     regulator;
		logic     reset_pin;
		logic     usb;
		logic     key;
		logic     power;
		logic     busy;
		outcome_t oc;
	} pin_state_t;

	// Register copies
	logic        ctl, fbk, has_reg, turnoff;
	logic [15:0] imp_t, on_set_t, off_set_t, hold_t;

	// Sequencer state
	phase_t      ph;
	logic [15:0] count;
	logic        believed, target;
	logic        regulator_on, reset_on, usb_on, key_on;

	pin_state_t  expected_pins[$];
	pin_state_t  predicted;
	int          err_count;

	task automatic reset_model();
		ctl          = 1'b1;
		fbk          = 1'b0;
		has_reg      = 1'b1;
		turnoff      = 1'b0;
		imp_t        = IMPULSE_RST;
		on_set_t     = ON_SETTLE_RST;
		off_set_t    = OFF_SETTLE_RST;
		hold_t       = RESET_HOLD_RST;
		ph           = PH_IDLE;
		count        = '0;
		believed     = 1'b0;
		target       = 1'b0;
		regulator_on = 1'b0;
		reset_on     = 1'b1;
		usb_on       = 1'b1;
		key_on       = 1'b0;
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			CFG_HAS_CONTROL:   ctl       = data[0];
			CFG_HAS_FEEDBACK:  fbk       = data[0];
			CFG_HAS_REGULATOR: has_reg   = data[0];
			CFG_CAN_TURNOFF:   turnoff   = data[0];
			CFG_IMPULSE:       imp_t     = data;
			CFG_ON_SETTLE:     on_set_t  = data;
			CFG_OFF_SETTLE:    off_set_t = data;
			CFG_RESET_HOLD:    hold_t    = data;
			default: ;
		endcase
	endtask

	// Feedback pin wins, then a modem without key control counts as on
	function automatic logic reported(input logic fb);
		if (fbk)
			return fb;
		if (!ctl)
			return 1'b1;
		return believed;
	endfunction

	task automatic start_key_pulse();
		key_on = 1'b1;
		ph     = PH_KEY;
		count  = imp_t;
	endtask

	// Close a sequence and check the reported state against the target
	task automatic conclude(input logic fb, output outcome_t oc);
		believed = target;
		ph       = PH_IDLE;
		count    = '0;
		if (reported(fb) != target) begin
			if (has_reg && regulator_on)
				regulator_on = 1'b0;
			oc = OC_MISMATCH;
		end else begin
			oc = OC_OK;
		end
	endtask

	task automatic advance_phase(input logic fb, output outcome_t oc);
		oc = OC_NONE;
		case (ph)
			PH_RAMP: begin
				usb_on = 1'b1;
				start_key_pulse();
			end
			PH_KEY: begin
				key_on = 1'b0;
				ph     = PH_SETTLE;
				count  = target ? on_set_t : off_set_t;
			end
			PH_SETTLE: begin
				if (target) begin
					conclude(fb, oc);
				end else begin
					usb_on = 1'b0;
					ph     = PH_USBOFF;
					count  = WAIT_USBOFF;
				end
			end
			PH_USBOFF: begin
				reset_on = 1'b1;
				ph       = PH_RESET;
				count    = hold_t;
			end
			PH_RESET: begin
				reset_on     = 1'b0;
				regulator_on = 1'b0;
				conclude(fb, oc);
			end
			default: begin
				ph    = PH_IDLE;
				count = '0;
			end
		endcase
	endtask

	task automatic handle_request(input logic want_on, input logic fb, output outcome_t oc);
		oc = OC_NONE;
		if (ph != PH_IDLE || !ctl) begin
			oc = OC_REJECTED;
		end else if (reported(fb) != want_on) begin
			target = want_on;
			if (want_on) begin
				// Ramp the supply first unless it is already up or absent
				if (has_reg && !regulator_on) begin
					regulator_on = 1'b1;
					reset_on     = 1'b0;
					ph           = PH_RAMP;
					count        = WAIT_RAMP;
				end else begin
					start_key_pulse();
				end
			end else if (!turnoff) begin
				if (has_reg && regulator_on)
					regulator_on = 1'b0;
				oc = OC_REGONLY;
			end else begin
				start_key_pulse();
			end
		end
	endtask

	task automatic apply_event(input logic [1:0] op, input logic fb, output pin_state_t res);
		outcome_t oc;
		oc = OC_NONE;
		if (op == OP_ON || op == OP_OFF) begin
			handle_request(op == OP_ON, fb, oc);
		end else if (op == OP_TICK && ph != PH_IDLE) begin
			if (count <= 16'd1)
				advance_phase(fb, oc);
			else
				count = count - 16'd1;
		end
		res.regulator = regulator_on;
		res.reset_pin = reset_on;
		res.usb       = usb_on;
		res.key       = key_on;
		res.power     = reported(fb);
		res.busy      = (ph != PH_IDLE);
		res.oc        = oc;
	endtask

	function automatic string show(input pin_state_t s);
		return $sformatf("reg=%b rst=%b usb=%b key=%b pwr=%b busy=%b outcome=%0d",
			s.regulator, s.reset_pin, s.usb, s.key, s.power, s.busy, s.oc);
	endfunction

	// Compare each field of the result with the oldest prediction
	task automatic check_result();
		pin_state_t got, want;
		got.regulator = supply_enable;
		got.reset_pin = reset_level;
		got.usb       = usb_enable;
		got.key       = key_level;
		got.power     = powered;
		got.busy      = busy_res;
		got.oc        = outcome_t'(outcome);
		if (expected_pins.size() == 0) begin
			err_count++;
			if (err_count <= 10)
				$display("%0t: result with nothing outstanding: %s", $realtime, show(got));
		end else begin
			want = expected_pins.pop_front();
			if (got.regulator !== want.regulator || got.reset_pin !== want.reset_pin ||
					got.usb !== want.usb || got.key !== want.key ||
					got.power !== want.power || got.busy !== want.busy ||
					got.oc !== want.oc) begin
				err_count++;
				if (err_count <= 10)
					$display("%0t: mismatch, expected %s, got %s",
						$realtime, show(want), show(got));
			end
		end
	endtask

	// Track every transaction on the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			expected_pins.delete();
			err_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready) begin
				apply_event(opcode, feedback_level, predicted);
				expected_pins.push_back(predicted);
			end
			mismatches <= err_count;
			pending <= expected_pins.size();
		end
	end

endmodule

### verif/modem_power_sequencer_test.sv
`timescale 1ns / 1ps

module modem_power_sequencer_test;
	import mps_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT     = 4000;
	localparam int HOLD_OFF_CYCLES = 400;

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid, in_ready;
	logic [1:0]  opcode;
	logic        feedback_level;
	logic        out_valid, out_ready;
	logic        supply_enable, reset_level, usb_enable, key_level;
	logic        powered, busy_res;
	logic [2:0]  outcome;
	int          mismatches, pending;

	int   offer_idle_pct, ack_idle_pct;
	int   hold_requests, hold_served, hold_left;
	int   events_sent, results_seen, settings_applied, quiet;
	logic last_busy, fb_pin;

	modem_power_sequencer uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .feedback_level(feedback_level),
		.out_valid(out_valid), .out_ready(out_ready),
		.supply_enable(supply_enable), .reset_level(reset_level),
		.usb_enable(usb_enable), .key_level(key_level),
		.powered(powered), .busy_res(busy_res), .outcome(outcome)
	);

	power_sequence_checker seq_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .feedback_level(feedback_level),
		.out_valid(out_valid), .out_ready(out_ready),
		.supply_enable(supply_enable), .reset_level(reset_level),
		.usb_enable(usb_enable), .key_level(key_level),
		.powered(powered), .busy_res(busy_res), .outcome(outcome),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drive the result ready: long hold-offs on request, random stalls otherwise
	initial begin
		out_ready = 1'b0;
		hold_served = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_OFF_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= ack_idle_pct);
			end
		end
	end

	// Count quiet cycles and note the busy flag of each result
	initial begin
		quiet = 0;
		results_seen = 0;
		last_busy = 1'b0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (out_valid && out_ready) begin
				results_seen++;
				last_busy = busy_res;
			end
		end
		$display("Timeout after %0d cycles without a transaction", QUIET_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Offer one event and hold it until the transaction completes
	task automatic send_event(input logic [1:0] op, input logic fb);
		while ($urandom_range(99) < offer_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		feedback_level <= fb;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		events_sent++;
	endtask

	// Stop offering until every predicted result has come back
	task automatic await_settled();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic ctl, input logic fbk, input logic has_reg,
			input logic turnoff, input logic [15:0] imp, input logic [15:0] on_set,
			input logic [15:0] off_set, input logic [15:0] hold);
		logic [15:0] spare;
		spare = 16'($urandom);
		await_settled();
		cfg_write(CFG_HAS_CONTROL, {spare[15:1], ctl});
		cfg_write(CFG_HAS_FEEDBACK, {~spare[15:1], fbk});
		cfg_write(CFG_HAS_REGULATOR, {spare[15:1], has_reg});
		cfg_write(CFG_CAN_TURNOFF, {~spare[15:1], turnoff});
		cfg_write(CFG_IMPULSE, imp);
		cfg_write(CFG_ON_SETTLE, on_set);
		cfg_write(CFG_OFF_SETTLE, off_set);
		cfg_write(CFG_RESET_HOLD, hold);
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	// Tick until the sequencer reports idle
	task automatic run_out_sequence();
		await_settled();
		while (last_busy) begin
			repeat (32) send_event(OP_TICK, fb_pin);
			await_settled();
		end
	endtask

	// Mostly a request followed by a burst of ticks, with noise mixed in
	task automatic random_episodes(input int quota);
		int   first, r, n;
		logic want_on;
		first = events_sent;
		while (events_sent - first < quota) begin
			r = $urandom_range(99);
			if (r < 70) begin
				want_on = 1'($urandom_range(1));
				send_event(want_on ? OP_ON : OP_OFF, fb_pin);
				if ($urandom_range(99) < 80)
					fb_pin = want_on;
				n = ($urandom_range(99) < 80) ? $urandom_range(1, 25) : $urandom_range(150, 240);
				for (int k = 0; k < n && events_sent - first < quota; k++) begin
					if ($urandom_range(99) < 5)
						send_event(2'($urandom_range(3)), fb_pin);
					else
						send_event(OP_TICK, fb_pin);
					if ($urandom_range(99) < 3)
						fb_pin = ~fb_pin;
				end
			end else if (r < 85) begin
				send_event($urandom_range(1) ? OP_TICK : OP_UNUSED, 1'($urandom_range(1)));
			end else begin
				send_event($urandom_range(1) ? OP_ON : OP_OFF, 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_TICK;
		feedback_level = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HAS_CONTROL;
		cfg_data = '0;
		hold_requests = 0;
		events_sent = 0;
		settings_applied = 0;
		fb_pin = 1'b0;
		offer_idle_pct = 7;
		ack_idle_pct = 53;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: no regulator, zero-length key pulse, short waits
		apply_setting(1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 16'd1, 16'd2, 16'd1);
		send_event(OP_TICK, 1'b0);      // tick while idle
		send_event(OP_UNUSED, 1'b1);    // unused opcode while idle
		send_event(OP_OFF, 1'b0);       // already off
		send_event(OP_ON, 1'b1);        // straight to the key pulse
		send_event(OP_ON, 1'b0);        // busy
		send_event(OP_OFF, 1'b1);       // busy
		send_event(OP_UNUSED, 1'b0);    // unused opcode mid-sequence
		send_event(OP_TICK, 1'b0);
		send_event(OP_TICK, 1'b1);      // finish powered on
		send_event(OP_ON, 1'b0);        // already on
		send_event(OP_OFF, 1'b1);       // full power-off path
		for (int i = 0; i < 14; i++)
			send_event(OP_TICK, i[0]);

		// Directed: no key control, then off refused and a ramped power-on
		apply_setting(1'b0, 1'b1, 1'b1, 1'b0, IMPULSE_RST, ON_SETTLE_RST,
			OFF_SETTLE_RST, RESET_HOLD_RST);
		send_event(OP_ON, 1'b0);
		send_event(OP_OFF, 1'b1);
		apply_setting(1'b1, 1'b1, 1'b1, 1'b0, 16'd3, 16'd2, 16'd1, 16'd1);
		send_event(OP_OFF, 1'b1);
		send_event(OP_ON, 1'b1);
		send_event(OP_ON, 1'b0);

		// Random, sender rarely idle and receiver often stalled
		apply_setting(1'b1, 1'b0, 1'b1, 1'b1, 16'd2, 16'd3, 16'd1, 16'd2);
		random_episodes(150);
		apply_setting(1'b1, 1'b1, 1'b1, 1'b0, 16'($urandom_range(3)),
			16'($urandom_range(3)), 16'd1, 16'd0);
		hold_requests++;
		random_episodes(130);

		// Random, the other way round
		offer_idle_pct = 53;
		ack_idle_pct = 7;
		run_out_sequence();
		apply_setting(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_episodes(60);
		apply_setting(1'b1, 1'b1, 1'b0, 1'b1, 16'd1, 16'd0, 16'd0, 16'd3);
		random_episodes(70);
		await_settled();
		random_episodes(70);

		// Random at full rate but for a long receiver hold-off
		offer_idle_pct = 0;
		ack_idle_pct = 0;
		apply_setting(1'b1, 1'b0, 1'b1, 1'($urandom_range(1)), 16'd5, 16'd4, 16'd3, 16'd1);
		hold_requests++;
		random_episodes(130);

		// One power-on with a long key pulse
		run_out_sequence();
		apply_setting(1'b1, 1'b0, 1'b0, 1'b1, 16'd120, 16'd1, 16'd1, 16'hFFFF);
		send_event(OP_ON, 1'b0);
		send_event(OP_OFF, 1'b0);
		run_out_sequence();

		await_settled();
		repeat (10) @(negedge clk);
		$display("Drove %0d input transactions over %0d register settings, including",
			events_sent, settings_applied);
		$display("long receiver hold-offs and a long key pulse; %0d results compared.",
			results_seen);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
